[hdl/esf_pkg.sv]
// Package for the ellipsoid soft force unit: shared types and constants.
// Depends on nothing.
`default_nettype none
package esf_pkg;
    localparam int FORCE_BITS = 32;
    localparam int INV_BITS = 32;
    localparam int STIFF_BITS = 24;
    localparam int OUT_INDEX_BITS = 16;

    localparam logic [1:0] MODE_NONE = 2'd0;
    localparam logic [1:0] MODE_ONE = 2'd1;
    localparam logic [1:0] MODE_TWO = 2'd2;
    localparam logic [1:0] MODE_OUTSIDE = 2'd3;
    localparam logic [1:0] DIMS_TWO = 2'd2;

    localparam logic [2:0] REG_FORCE_MODE = 3'd0;
    localparam logic [2:0] REG_DIMENSIONS = 3'd1;
    localparam logic [2:0] REG_INV_A = 3'd2;
    localparam logic [2:0] REG_INV_B_UPPER = 3'd3;
    localparam logic [2:0] REG_INV_B_LOWER = 3'd4;
    localparam logic [2:0] REG_INV_C = 3'd5;
    localparam logic [2:0] REG_STIFFNESS = 3'd6;

    localparam logic [16:0] E_ONE = 17'h10000;

    typedef struct packed {
        logic       applied;
        logic       last;
        logic [15:0] index;
    } tag_t;
endpackage
`default_nettype wire

[hdl/ellipsoid_soft_force_unit.sv]
// Ellipsoid soft force unit, top level.
// Throughput: one request per cycle while the input is not stalled.
// Pipelined front (3 stages) and back (5 stages) feed a 16-entry result queue;
// input stalls when the queue cannot absorb all requests in flight.
// Reset: asynchronous active-low; registers return to defaults, pipeline empties.
// Depends on esf_pkg, esf_front, esf_back, esf_queue.
`default_nettype none
module ellipsoid_soft_force_unit #(
    parameter int COORD_BITS = 24,
    parameter int INDEX_BITS = 16
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_we,
    input  wire logic [2:0]                   cfg_index,
    input  wire logic [31:0]                  cfg_data,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic [INDEX_BITS-1:0]        point_index,
    input  wire logic signed [COORD_BITS-1:0] pos_x,
    input  wire logic signed [COORD_BITS-1:0] pos_y,
    input  wire logic signed [COORD_BITS-1:0] pos_z,
    input  wire logic                         last_point,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic [15:0]                       point_index_res,
    output logic signed [31:0]                force_x,
    output logic signed [31:0]                force_y,
    output logic signed [31:0]                force_z,
    output logic                              force_applied,
    output logic                              saturated,
    output logic                              last_point_res
);
    localparam int CW = COORD_BITS;
    localparam int DEPTH = 16;
    localparam int QW = 18 + 96 + 1;

    logic [1:0] mode_reg, dims_reg;
    logic [31:0] ia_reg, ibu_reg, ibl_reg, ic_reg;
    logic [23:0] st_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= esf_pkg::MODE_NONE;
            dims_reg <= 2'd3;
            ia_reg <= 32'd68719;
            ibu_reg <= 32'd724401;
            ibl_reg <= 32'd724401;
            ic_reg <= 32'd724401;
            st_reg <= 24'd5500;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                esf_pkg::REG_FORCE_MODE:  mode_reg <= cfg_data[1:0];
                esf_pkg::REG_DIMENSIONS:  dims_reg <= cfg_data[1:0];
                esf_pkg::REG_INV_A:       ia_reg <= cfg_data;
                esf_pkg::REG_INV_B_UPPER: ibu_reg <= cfg_data;
                esf_pkg::REG_INV_B_LOWER: ibl_reg <= cfg_data;
                esf_pkg::REG_INV_C:       ic_reg <= cfg_data;
                esf_pkg::REG_STIFFNESS:   st_reg <= cfg_data[23:0];
                default: ;
            endcase
        end
    end

    logic [15:0] idx16;
    assign idx16 = 16'(point_index);

    logic in_go;
    logic [3:0] fly_reg;
    logic [$clog2(DEPTH+1)-1:0] qcount;
    assign in_stall = (32'(qcount) + 32'(fly_reg)) >= DEPTH;
    assign in_go = in_valid && !in_stall;

    logic f_valid, f_eneg;
    esf_pkg::tag_t f_tag;
    logic [2*CW+32:0] f_emag;
    logic [CW+33:0] f_gx, f_gy, f_gz;
    logic [2:0] f_cneg;

    esf_front #(.CW(CW)) u_front (
        .clk(clk), .rst_n(rst_n), .in_go(in_go),
        .force_mode(mode_reg), .dimensions(dims_reg),
        .inv_a(ia_reg), .inv_bu(ibu_reg), .inv_bl(ibl_reg), .inv_c(ic_reg),
        .idx(idx16), .px(pos_x), .py(pos_y), .pz(pos_z), .lastp(last_point),
        .f_valid(f_valid), .f_tag(f_tag), .f_eneg(f_eneg), .f_emag(f_emag),
        .f_gx(f_gx), .f_gy(f_gy), .f_gz(f_gz), .f_cneg(f_cneg)
    );

    logic r_valid, r_sat;
    esf_pkg::tag_t r_tag;
    logic [31:0] r_fx, r_fy, r_fz;

    esf_back #(.CW(CW)) u_back (
        .clk(clk), .rst_n(rst_n), .b_go(f_valid), .stiff(st_reg),
        .b_tag(f_tag), .b_eneg(f_eneg), .b_emag(f_emag),
        .b_gx(f_gx), .b_gy(f_gy), .b_gz(f_gz), .b_cneg(f_cneg),
        .r_valid(r_valid), .r_tag(r_tag), .r_fx(r_fx), .r_fy(r_fy), .r_fz(r_fz),
        .r_sat(r_sat)
    );

    logic out_go;
    logic [QW-1:0] qdata;
    assign out_go = out_valid && !out_stall;

    esf_queue #(.W(QW), .DEPTH(DEPTH)) u_queue (
        .clk(clk), .rst_n(rst_n), .wr(r_valid),
        .wdata({r_tag, r_fx, r_fy, r_fz, r_sat}),
        .rd(out_go), .rdata(qdata), .nonempty(out_valid), .count(qcount)
    );

    esf_pkg::tag_t q_tag;
    assign q_tag = qdata[QW-1:97];
    assign point_index_res = q_tag.index;
    assign force_applied = q_tag.applied;
    assign last_point_res = q_tag.last;
    assign force_x = qdata[96:65];
    assign force_y = qdata[64:33];
    assign force_z = qdata[32:1];
    assign saturated = qdata[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fly_reg <= '0;
        else
            fly_reg <= fly_reg + {3'd0, in_go} - {3'd0, r_valid};
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        r_valid |-> (qcount < DEPTH || out_go))
        else $error("result queue overflow");
    a_fly_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(qcount) + 32'(fly_reg)) <= DEPTH)
        else $error("requests in flight exceed queue space");
    a_sat_applied: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && saturated) |-> force_applied)
        else $error("saturation without applied force");
`endif
endmodule
`default_nettype wire

[hdl/esf_front.sv]
// Front stage: accepts a point request, forms the residual E and gradients.
// Depends on esf_pkg.
`default_nettype none
module esf_front #(
    parameter int CW = 24
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_go,
    input  wire logic [1:0]           force_mode,
    input  wire logic [1:0]           dimensions,
    input  wire logic [31:0]          inv_a,
    input  wire logic [31:0]          inv_bu,
    input  wire logic [31:0]          inv_bl,
    input  wire logic [31:0]          inv_c,
    input  wire logic [15:0]          idx,
    input  wire logic signed [CW-1:0] px,
    input  wire logic signed [CW-1:0] py,
    input  wire logic signed [CW-1:0] pz,
    input  wire logic                 lastp,
    output logic                      f_valid,
    output esf_pkg::tag_t             f_tag,
    output logic                      f_eneg,
    output logic [2*CW+32:0]          f_emag,
    output logic [CW+33:0]            f_gx,
    output logic [CW+33:0]            f_gy,
    output logic [CW+33:0]            f_gz,
    output logic [2:0]                f_cneg
);
    localparam int SW = 2 * CW + 34;
    logic [CW-1:0] xm, ym, zm;
    logic [31:0] ib;
    always_comb
    begin
        xm = px[CW-1] ? CW'(-px) : CW'(px);
        ym = py[CW-1] ? CW'(-py) : CW'(py);
        zm = pz[CW-1] ? CW'(-pz) : CW'(pz);
        ib = (force_mode == esf_pkg::MODE_TWO && (py[CW-1] || ym == '0)) ? inv_bl : inv_bu;
    end

    // stage 1: squares
    logic v1_reg, v2_reg, v3_reg;
    logic [2*CW-1:0] sx_reg, sy_reg, sz_reg;
    logic [31:0] ia_reg, ib_reg, ic_reg;
    logic [CW-1:0] xm_reg, ym_reg, zm_reg;
    logic [2:0] cn_reg;
    logic md_reg, dz_reg, out_reg;
    esf_pkg::tag_t t1_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_go;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end
    always_ff @(posedge clk)
    begin
        sx_reg <= xm * xm;
        sy_reg <= ym * ym;
        sz_reg <= zm * zm;
        ia_reg <= inv_a;
        ib_reg <= ib;
        ic_reg <= inv_c;
        xm_reg <= xm;
        ym_reg <= ym;
        zm_reg <= zm;
        cn_reg <= {pz[CW-1], py[CW-1], px[CW-1]};
        md_reg <= force_mode != esf_pkg::MODE_NONE;
        out_reg <= force_mode == esf_pkg::MODE_OUTSIDE;
        dz_reg <= dimensions != esf_pkg::DIMS_TWO;
        t1_reg <= '{applied: 1'b0, last: lastp, index: idx};
    end

    // stage 2: split term products and gradient products
    logic [63:0] sxe, sye, sze, lx, ly, lz;
    always_comb
    begin
        sxe = 64'(sx_reg);
        sye = 64'(sy_reg);
        sze = 64'(sz_reg);
        lx = sxe[31:0] * ia_reg;
        ly = sye[31:0] * ib_reg;
        lz = sze[31:0] * ic_reg;
    end
    logic [63:0] hx_reg, hy_reg, hz_reg;
    logic [31:0] lx_reg, ly_reg, lz_reg;
    logic [CW+31:0] gx_reg, gy_reg, gz_reg;
    logic [2:0] cn2_reg;
    logic md2_reg, out2_reg;
    esf_pkg::tag_t t2_reg;
    always_ff @(posedge clk)
    begin
        hx_reg <= sxe[63:32] * ia_reg;
        hy_reg <= sye[63:32] * ib_reg;
        hz_reg <= dz_reg ? sze[63:32] * ic_reg : '0;
        lx_reg <= lx[63:32];
        ly_reg <= ly[63:32];
        lz_reg <= dz_reg ? lz[63:32] : '0;
        gx_reg <= xm_reg * ia_reg;
        gy_reg <= ym_reg * ib_reg;
        gz_reg <= zm_reg * ic_reg;
        cn2_reg <= cn_reg;
        md2_reg <= md_reg;
        out2_reg <= out_reg;
        t2_reg <= t1_reg;
    end

    // stage 3: terms, E
    logic [SW-1:0] tx, ty, tz, sum;
    always_comb
    begin
        tx = SW'(hx_reg) + SW'(lx_reg);
        ty = SW'(hy_reg) + SW'(ly_reg);
        tz = SW'(hz_reg) + SW'(lz_reg);
        sum = tx + ty + tz;
    end
    always_ff @(posedge clk)
    begin
        f_eneg <= sum < SW'(esf_pkg::E_ONE);
        f_emag <= (sum < SW'(esf_pkg::E_ONE)) ? (2*CW+33)'(SW'(esf_pkg::E_ONE) - sum)
                                                : (2*CW+33)'(sum - SW'(esf_pkg::E_ONE));
        f_gx <= {1'b0, gx_reg, 1'b0};
        f_gy <= {1'b0, gy_reg, 1'b0};
        f_gz <= {1'b0, gz_reg, 1'b0};
        f_cneg <= cn2_reg;
        f_tag <= '{applied: md2_reg && !(out2_reg && sum < SW'(esf_pkg::E_ONE)),
                   last: t2_reg.last, index: t2_reg.index};
    end
    assign f_valid = v3_reg;
endmodule
`default_nettype wire

[hdl/esf_back.sv]
// Back stage: forms each force component from E, gradient and stiffness.
// Depends on esf_pkg.
`default_nettype none
module esf_back #(
    parameter int CW = 24
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                b_go,
    input  wire logic [23:0]         stiff,
    input  esf_pkg::tag_t            b_tag,
    input  wire logic                b_eneg,
    input  wire logic [2*CW+32:0]    b_emag,
    input  wire logic [CW+33:0]      b_gx,
    input  wire logic [CW+33:0]      b_gy,
    input  wire logic [CW+33:0]      b_gz,
    input  wire logic [2:0]          b_cneg,
    output logic                     r_valid,
    output esf_pkg::tag_t            r_tag,
    output logic [31:0]              r_fx,
    output logic [31:0]              r_fy,
    output logic [31:0]              r_fz,
    output logic                     r_sat
);
    localparam int LB = 24;
    localparam int GB = 32;
    localparam int NE = (2 * CW + LB - 1) / LB;
    localparam int NS = NE + 1;
    localparam int NG = (CW + 34 + GB - 1) / GB;
    localparam int NP = NS * NG;
    localparam int PW = NS * LB + NG * GB;
    localparam int DW = $bits(esf_pkg::tag_t) + 4;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic [DW-1:0] d1_reg, d2_reg, d3_reg, d4_reg;
    logic [2*LB-1:0] ep_reg [NE];
    logic [NG*GB-1:0] gx1_reg, gy1_reg, gz1_reg, gx2_reg, gy2_reg, gz2_reg;
    logic [NS*LB-1:0] es_next, es_reg;
    logic [LB+GB-1:0] ppx_reg [NP];
    logic [LB+GB-1:0] ppy_reg [NP];
    logic [LB+GB-1:0] ppz_reg [NP];
    logic [PW-1:0] sx_next, sy_next, sz_next, px_reg, py_reg, pz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= b_go;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // stage 1: E limbs times stiffness
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NE; i++)
            ep_reg[i] <= b_emag[i*LB +: LB] * stiff;
        gx1_reg <= (NG*GB)'(b_gx);
        gy1_reg <= (NG*GB)'(b_gy);
        gz1_reg <= (NG*GB)'(b_gz);
        d1_reg <= {b_tag, b_eneg, b_cneg};
    end

    // stage 2: combine E times stiffness
    always_comb
    begin
        es_next = '0;
        for (int i = 0; i < NE; i++)
            es_next = es_next + ((NS*LB)'(ep_reg[i]) << (i * LB));
    end
    always_ff @(posedge clk)
    begin
        es_reg <= es_next;
        gx2_reg <= gx1_reg;
        gy2_reg <= gy1_reg;
        gz2_reg <= gz1_reg;
        d2_reg <= d1_reg;
    end

    // stage 3: partial products with the gradient limbs
    always_ff @(posedge clk)
    begin
        for (int j = 0; j < NS; j++)
            for (int k = 0; k < NG; k++)
            begin
                ppx_reg[j*NG+k] <= es_reg[j*LB +: LB] * gx2_reg[k*GB +: GB];
                ppy_reg[j*NG+k] <= es_reg[j*LB +: LB] * gy2_reg[k*GB +: GB];
                ppz_reg[j*NG+k] <= es_reg[j*LB +: LB] * gz2_reg[k*GB +: GB];
            end
        d3_reg <= d2_reg;
    end

    // stage 4: sum the partial products
    always_comb
    begin
        sx_next = '0;
        sy_next = '0;
        sz_next = '0;
        for (int j = 0; j < NS; j++)
            for (int k = 0; k < NG; k++)
            begin
                sx_next = sx_next + (PW'(ppx_reg[j*NG+k]) << (j * LB + k * GB));
                sy_next = sy_next + (PW'(ppy_reg[j*NG+k]) << (j * LB + k * GB));
                sz_next = sz_next + (PW'(ppz_reg[j*NG+k]) << (j * LB + k * GB));
            end
    end
    always_ff @(posedge clk)
    begin
        px_reg <= sx_next;
        py_reg <= sy_next;
        pz_reg <= sz_next;
        d4_reg <= d3_reg;
    end

    function automatic logic [32:0] clampf(input logic [PW-1:0] p, input logic neg);
        logic [PW-49:0] m;
        logic big;
        m = p[PW-1:48];
        big = m[PW-49:31] != '0;
        if (big && neg && m == (PW-48)'(33'h80000000))
            clampf = {1'b0, 32'h80000000};
        else if (big)
            clampf = {1'b1, neg ? 32'h80000000 : 32'h7FFFFFFF};
        else if (neg)
            clampf = {1'b0, 32'(-m[31:0])};
        else
            clampf = {1'b0, m[31:0]};
    endfunction

    esf_pkg::tag_t t4;
    logic en4;
    logic [2:0] cn4;
    assign t4 = d4_reg[DW-1:4];
    assign en4 = d4_reg[3];
    assign cn4 = d4_reg[2:0];

    logic [32:0] cx, cy, cz;
    always_comb
    begin
        cx = clampf(px_reg, !(en4 ^ cn4[0]));
        cy = clampf(py_reg, !(en4 ^ cn4[1]));
        cz = clampf(pz_reg, !(en4 ^ cn4[2]));
    end
    always_ff @(posedge clk)
    begin
        r_tag <= t4;
        r_fx <= t4.applied ? cx[31:0] : '0;
        r_fy <= t4.applied ? cy[31:0] : '0;
        r_fz <= t4.applied ? cz[31:0] : '0;
        r_sat <= t4.applied && (cx[32] || cy[32] || cz[32]);
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            r_valid <= 1'b0;
        else
            r_valid <= v4_reg;
    end
endmodule
`default_nettype wire

[hdl/esf_queue.sv]
// Result queue: holds finished force requests until the sink takes them.
// Depends on nothing.
`default_nettype none
module esf_queue #(
    parameter int W = 118,
    parameter int DEPTH = 8
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         wr,
    input  wire logic [W-1:0] wdata,
    input  wire logic         rd,
    output logic [W-1:0]      rdata,
    output logic              nonempty,
    output logic [$clog2(DEPTH+1)-1:0] count
);
    localparam int AW = $clog2(DEPTH);
    logic [W-1:0] mem [DEPTH];
    logic [AW-1:0] wp_reg, rp_reg;
    logic [$clog2(DEPTH+1)-1:0] cnt_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr)
                wp_reg <= AW'(wp_reg + 1'b1);
            if (rd)
                rp_reg <= AW'(rp_reg + 1'b1);
            cnt_reg <= cnt_reg + {{($bits(cnt_reg)-1){1'b0}}, wr}
                               - {{($bits(cnt_reg)-1){1'b0}}, rd};
        end
    end
    always_ff @(posedge clk)
    begin
        if (wr)
            mem[wp_reg] <= wdata;
    end
    assign rdata = mem[rp_reg];
    assign nonempty = cnt_reg != '0;
    assign count = cnt_reg;
endmodule
`default_nettype wire

[bench/esf_checker.sv]
// Checker for the ellipsoid soft force unit: mirrors the register writes, predicts
// the force of every accepted request and compares results in order.
// Depends on esf_pkg.
`timescale 1ns / 1ps
module esf_checker (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [31:0]        cfg_data,
    input  wire logic               in_valid,
    input  wire logic               in_stall,
    input  wire logic [15:0]        point_index,
    input  wire logic signed [23:0] pos_x,
    input  wire logic signed [23:0] pos_y,
    input  wire logic signed [23:0] pos_z,
    input  wire logic               last_point,
    input  wire logic               out_valid,
    input  wire logic               out_stall,
    input  wire logic [15:0]        point_index_res,
    input  wire logic signed [31:0] force_x,
    input  wire logic signed [31:0] force_y,
    input  wire logic signed [31:0] force_z,
    input  wire logic               force_applied,
    input  wire logic               saturated,
    input  wire logic               last_point_res,
    output int                      fail_count,
    output int                      pending
);
    typedef struct packed {
        logic [15:0] index;
        logic [31:0] fx;
        logic [31:0] fy;
        logic [31:0] fz;
        logic        applied;
        logic        sat;
        logic        last;
    } force_t;

    force_t force_queue[$];

    logic [1:0]  mode_r;
    logic [1:0]  dims_r;
    logic [31:0] inv_a_r;
    logic [31:0] inv_bu_r;
    logic [31:0] inv_bl_r;
    logic [31:0] inv_c_r;
    logic [23:0] stiff_r;

    function automatic logic [23:0] magnitude(input logic [23:0] v);
        return v[23] ? (~v + 24'd1) : v;
    endfunction

    function automatic logic [49:0] axis_term(input logic [23:0] m, input logic [31:0] inv);
        logic [79:0] prod;
        prod = 80'(m) * 80'(m) * 80'(inv);
        return 50'(prod >> 32);
    endfunction

    function automatic logic [31:0] component(input logic [49:0] emag, input bit eneg,
                                              input logic [23:0] cmag, input bit cneg,
                                              input logic [31:0] inv, inout bit sat);
        logic [57:0]  grad;
        logic [139:0] prod;
        logic [30:0]  mag;
        bit           over;
        bit           neg;
        grad = 58'(cmag) * 58'(inv) * 58'd2;
        prod = 140'(emag) * 140'(grad) * 140'(stiff_r);
        mag  = prod[78:48];
        over = |prod[139:79];
        neg  = !(eneg ^ cneg);
        if (over) begin
            if (neg && prod[79] && !(|prod[139:80]) && mag == 31'd0)
                return 32'h80000000;
            sat = 1'b1;
            return neg ? 32'h80000000 : 32'h7FFFFFFF;
        end
        return neg ? (~{1'b0, mag} + 32'd1) : {1'b0, mag};
    endfunction

    function automatic force_t predict_force(input logic [15:0] idx, input logic [23:0] x,
                                             input logic [23:0] y, input logic [23:0] z,
                                             input logic last);
        force_t      r;
        logic [23:0] xm, ym, zm;
        logic [31:0] inv_b;
        logic [49:0] sum, emag;
        bit          eneg;
        bit          sat;
        xm = magnitude(x);
        ym = magnitude(y);
        zm = magnitude(z);
        sat = 1'b0;
        r = '0;
        r.index = idx;
        r.last = last;
        if (mode_r != esf_pkg::MODE_NONE) begin
            inv_b = (mode_r == esf_pkg::MODE_TWO && (y[23] || ym == 24'd0)) ? inv_bl_r
                                                                             : inv_bu_r;
            sum = axis_term(xm, inv_a_r) + axis_term(ym, inv_b);
            if (dims_r != esf_pkg::DIMS_TWO)
                sum = sum + axis_term(zm, inv_c_r);
            eneg = sum < 50'h10000;
            emag = eneg ? (50'h10000 - sum) : (sum - 50'h10000);
            if (mode_r != esf_pkg::MODE_OUTSIDE || !eneg) begin
                r.applied = 1'b1;
                r.fx = component(emag, eneg, xm, x[23], inv_a_r, sat);
                r.fy = component(emag, eneg, ym, y[23], inv_b, sat);
                r.fz = component(emag, eneg, zm, z[23], inv_c_r, sat);
            end
        end
        r.sat = sat;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        force_t want;
        if (!rst_n) begin
            mode_r   <= esf_pkg::MODE_NONE;
            dims_r   <= 2'd3;
            inv_a_r  <= 32'd68719;
            inv_bu_r <= 32'd724401;
            inv_bl_r <= 32'd724401;
            inv_c_r  <= 32'd724401;
            stiff_r  <= 24'd5500;
            fail_count <= 0;
            pending <= 0;
        end else begin
            if (in_valid && !in_stall)
                force_queue.push_back(predict_force(point_index, pos_x, pos_y, pos_z,
                                                    last_point));
            if (out_valid && !out_stall) begin
                if (force_queue.size() == 0) begin
                    $display("%0t: result for point %0d with nothing expected", $time,
                             point_index_res);
                    fail_count <= fail_count + 1;
                end else begin
                    want = force_queue.pop_front();
                    if (want != {point_index_res, force_x, force_y, force_z, force_applied,
                                 saturated, last_point_res}) begin
                        $display("%0t: mismatch expected idx=%0d f=%h/%h/%h app=%b sat=%b last=%b",
                                 $time, want.index, want.fx, want.fy, want.fz, want.applied,
                                 want.sat, want.last);
                        $display("%0t:          actual   idx=%0d f=%h/%h/%h app=%b sat=%b last=%b",
                                 $time, point_index_res, force_x, force_y, force_z,
                                 force_applied, saturated, last_point_res);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            pending <= force_queue.size();
            if (cfg_we) begin
                case (cfg_index)
                    esf_pkg::REG_FORCE_MODE:  mode_r   <= cfg_data[1:0];
                    esf_pkg::REG_DIMENSIONS:  dims_r   <= cfg_data[1:0];
                    esf_pkg::REG_INV_A:       inv_a_r  <= cfg_data;
                    esf_pkg::REG_INV_B_UPPER: inv_bu_r <= cfg_data;
                    esf_pkg::REG_INV_B_LOWER: inv_bl_r <= cfg_data;
                    esf_pkg::REG_INV_C:       inv_c_r  <= cfg_data;
                    esf_pkg::REG_STIFFNESS:   stiff_r  <= cfg_data[23:0];
                    default: ;
                endcase
            end
        end
    end
endmodule

[bench/ellipsoid_soft_force_unit_tb.sv]
// Top of the ellipsoid soft force testbench: clock, reset, register phases, point
// stimulus, result back-pressure and verdict. Depends on esf_pkg, esf_checker
// and the unit under test.
`timescale 1ns / 1ps
module ellipsoid_soft_force_unit_tb;
    localparam int IDLE_LIMIT = 3000;
    localparam int LONG_HOLD = 250;
    localparam int HOLD_AT = 300;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic [2:0]         cfg_index = esf_pkg::REG_FORCE_MODE;
    logic [31:0]        cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [15:0]        point_index = '0;
    logic signed [23:0] pos_x = '0;
    logic signed [23:0] pos_y = '0;
    logic signed [23:0] pos_z = '0;
    logic               last_point = 1'b0;
    logic               out_valid;
    logic               out_stall = 1'b1;
    logic [15:0]        point_index_res;
    logic signed [31:0] force_x, force_y, force_z;
    logic               force_applied, saturated, last_point_res;
    int                 fail_count;
    int                 pending;
    int                 idle_cycles = 0;
    int                 sent = 0;
    bit                 quiet = 1'b0;
    bit                 hold_request = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    ellipsoid_soft_force_unit DUT (.*);

    esf_checker u_checker (.*);

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        int gap;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if (hold_request) begin
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                hold_request = 1'b0;
            end
            gap = quiet ? 0 : $urandom_range(0, 13);
            if (gap > 0) begin
                out_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    task automatic send_point(input logic [15:0] idx, input logic [23:0] x,
                              input logic [23:0] y, input logic [23:0] z, input logic last);
        int gap;
        point_index <= idx;
        pos_x <= x;
        pos_y <= y;
        pos_z <= z;
        last_point <= last;
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
        sent++;
        if (sent == HOLD_AT)
            hold_request = 1'b1;
        gap = quiet ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    function automatic logic [23:0] rand_coord();
        case ($urandom_range(0, 3))
            0: return 24'($urandom);
            1: return 24'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
            2: return 24'($signed($urandom_range(0, 1 << 16)) - (1 << 15));
            default: return 24'($signed($urandom_range(0, 512)) - 256);
        endcase
    endfunction

    task automatic directed_points;
        send_point(16'h0000, 24'h000000, 24'h000000, 24'h000000, 1'b0);
        send_point(16'hFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 1'b1);
        send_point(16'h0001, 24'h800000, 24'h800000, 24'h800000, 1'b0);
        send_point(16'h0002, 24'h00FA00, 24'h000000, 24'h000000, 1'b0);
        send_point(16'h0003, 24'hFF0600, 24'h000000, 24'h000000, 1'b0);
        send_point(16'h0004, 24'h000000, 24'h004D00, 24'h000000, 1'b0);
        send_point(16'h0005, 24'h000000, 24'hFFB300, 24'h000000, 1'b0);
        send_point(16'h0006, 24'h000000, 24'h000000, 24'h004D00, 1'b0);
        send_point(16'h0007, 24'h000100, 24'hFFFF00, 24'h000080, 1'b0);
        send_point(16'h0008, 24'h000000, 24'h000000, 24'hFFB300, 1'b1);
        send_point(16'h5555, 24'h555555, 24'hAAAAAA, 24'h555555, 1'b0);
        send_point(16'hAAAA, 24'hAAAAAA, 24'h555555, 24'hAAAAAA, 1'b1);
    endtask

    task automatic run_phase(input logic [1:0] mode, input logic [1:0] dims,
                             input logic [31:0] ia, input logic [31:0] ibu,
                             input logic [31:0] ibl, input logic [31:0] ic,
                             input logic [23:0] stiff, input int count);
        drain();
        write_reg(esf_pkg::REG_FORCE_MODE, {30'd0, mode});
        write_reg(esf_pkg::REG_DIMENSIONS, {30'd0, dims});
        write_reg(esf_pkg::REG_INV_A, ia);
        write_reg(esf_pkg::REG_INV_B_UPPER, ibu);
        write_reg(esf_pkg::REG_INV_B_LOWER, ibl);
        write_reg(esf_pkg::REG_INV_C, ic);
        write_reg(esf_pkg::REG_STIFFNESS, {8'd0, stiff});
        directed_points();
        repeat (count)
            send_point(16'($urandom), rand_coord(), rand_coord(), rand_coord(),
                       1'($urandom_range(0, 1)));
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        repeat (20)
            send_point(16'($urandom), rand_coord(), rand_coord(), rand_coord(), 1'b0);
        run_phase(esf_pkg::MODE_ONE, 2'd3, 32'd68719, 32'd724401, 32'd724401, 32'd724401,
                  24'd5500, 192);
        run_phase(esf_pkg::MODE_TWO, 2'd3, 32'd68719, 32'd724401, 32'd2000000, 32'd724401,
                  24'd5500, 192);
        run_phase(esf_pkg::MODE_OUTSIDE, esf_pkg::DIMS_TWO, 32'd68719, 32'd724401,
                  32'd724401, 32'd90000, 24'd5500, 192);
        quiet = 1'b1;
        run_phase(esf_pkg::MODE_NONE, 2'd3, 32'h12345678, 32'h9ABCDEF0, 32'h0F0F0F0F,
                  32'hF0F0F0F0, 24'hFFFFFF, 192);
        quiet = 1'b0;
        run_phase(esf_pkg::MODE_ONE, 2'd0, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
                  32'hFFFFFFFF, 24'hFFFFFF, 192);
        run_phase(esf_pkg::MODE_TWO, 2'd1, 32'd0, 32'd0, 32'd0, 32'd0, 24'd0, 192);
        run_phase(esf_pkg::MODE_OUTSIDE, 2'd3, 32'd1000, 32'hFFFFFFFF, 32'd0, 32'd50000000,
                  24'd1, 192);
        run_phase(esf_pkg::MODE_TWO, esf_pkg::DIMS_TWO, 32'd3000000, 32'd40000000, 32'd700,
                  32'h80000000, 24'd123456, 192);
        drain();
        $display("Sent %0d points through all four force modes, both dimension settings,",
                 sent);
        $display("zero and full-scale axes and stiffness, with random stalls on both sides.");
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

[files.f]
hdl/esf_pkg.sv
hdl/esf_front.sv
hdl/esf_back.sv
hdl/esf_queue.sv
hdl/ellipsoid_soft_force_unit.sv
bench/esf_checker.sv
bench/ellipsoid_soft_force_unit_tb.sv
